// ----- src/akd_pkg.sv -----
// ----------------------------------------------------------------------------
// akd_pkg
// Shared types and constants for the ADC ladder key debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package akd_pkg;

    // Key codes shared by decode, tracking and the output ports
    typedef enum logic [2:0] {
        BTN_NONE   = 3'd0,
        BTN_ADD    = 3'd1,
        BTN_DOWN   = 3'd2,
        BTN_REDUCE = 3'd3,
        BTN_BACK   = 3'd4,
        BTN_ENTER  = 3'd5
    } t_key;

    localparam int BOUND_BITS  = 12;
    localparam int WIN_BITS    = 2 * BOUND_BITS;
    localparam int TARGET_BITS = 4;
    localparam int CFG_IDX_BITS = 3;

    // One inclusive window: high bound in the upper half, low in the lower
    typedef struct packed {
        logic [BOUND_BITS-1:0] hi;
        logic [BOUND_BITS-1:0] lo;
    } t_window;

    typedef struct packed {
        t_window add_win;
        t_window reduce_win;
        t_window enter_win;
        t_window back_win;
        t_window down_win;
    } t_win_set;

    // Result of one tracker step
    typedef struct packed {
        t_key event_key;
        logic held;
    } t_track_res;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADD_WIN    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REDUCE_WIN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTER_WIN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BACK_WIN   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOWN_WIN   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STABLE_TGT = 3'd5;

    // Reset values of the configuration registers
    localparam logic [WIN_BITS-1:0]    RST_ADD_WIN    = 24'h708578;
    localparam logic [WIN_BITS-1:0]    RST_REDUCE_WIN = 24'h3841F4;
    localparam logic [WIN_BITS-1:0]    RST_ENTER_WIN  = 24'hCE4BB8;
    localparam logic [WIN_BITS-1:0]    RST_BACK_WIN   = 24'h89876C;
    localparam logic [WIN_BITS-1:0]    RST_DOWN_WIN   = 24'h190032;
    localparam logic [TARGET_BITS-1:0] RST_STABLE_TGT = 4'd3;

endpackage

`default_nettype wire

// ----- src/akd_decode.sv -----
// ----------------------------------------------------------------------------
// akd_decode
// Maps one ADC sample to a raw key through five prioritized windows.
// ----------------------------------------------------------------------------
`default_nettype none

module akd_decode
    import akd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire t_win_set               i_wins,
    output t_key                        o_raw_key
);

    localparam int CMP_BITS = (SAMPLE_BITS > BOUND_BITS) ? SAMPLE_BITS : BOUND_BITS;

    logic [CMP_BITS-1:0] sample_ext;

    assign sample_ext = CMP_BITS'(i_sample);

    function automatic logic in_win(input logic [CMP_BITS-1:0] s, input t_window w);
        logic [CMP_BITS-1:0] lo_ext;
        logic [CMP_BITS-1:0] hi_ext;
        lo_ext = CMP_BITS'(w.lo);
        hi_ext = CMP_BITS'(w.hi);
        return (s >= lo_ext) && (s <= hi_ext);
    endfunction

    // Fixed priority: add, reduce, enter, back, down
    always_comb begin
        priority if (in_win(sample_ext, i_wins.add_win)) begin
            o_raw_key = BTN_ADD;
        end else if (in_win(sample_ext, i_wins.reduce_win)) begin
            o_raw_key = BTN_REDUCE;
        end else if (in_win(sample_ext, i_wins.enter_win)) begin
            o_raw_key = BTN_ENTER;
        end else if (in_win(sample_ext, i_wins.back_win)) begin
            o_raw_key = BTN_BACK;
        end else if (in_win(sample_ext, i_wins.down_win)) begin
            o_raw_key = BTN_DOWN;
        end else begin
            o_raw_key = BTN_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- src/akd_track.sv -----
// ----------------------------------------------------------------------------
// akd_track
// Debounce state: last raw key, saturating stability counter, pressed flag.
// ----------------------------------------------------------------------------
`default_nettype none

module akd_track
    import akd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire t_key                   i_raw_key,
    input  wire logic [TARGET_BITS-1:0] i_target,
    output t_track_res                  o_res
);

    t_key                   r_prev_key, n_prev_key;
    logic [TARGET_BITS-1:0] r_count, n_count;
    logic                   r_pressed, n_pressed;
    t_key                   event_key;

    // Next state for the transaction in flight
    always_comb begin
        n_prev_key = r_prev_key;
        n_count    = r_count;
        n_pressed  = r_pressed;
        event_key  = BTN_NONE;
        if (i_raw_key == r_prev_key) begin
            if (r_count < i_target) begin
                n_count = r_count + 1'b1;
            end
            if (n_count >= i_target) begin
                if (i_raw_key != BTN_NONE && !r_pressed) begin
                    n_pressed = 1'b1;
                    event_key = i_raw_key;
                end else if (i_raw_key == BTN_NONE && r_pressed) begin
                    n_pressed = 1'b0;
                end
            end
        end else begin
            n_prev_key = i_raw_key;
            n_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key <= BTN_NONE;
            r_count    <= '0;
            r_pressed  <= 1'b0;
        end else if (i_step) begin
            r_prev_key <= n_prev_key;
            r_count    <= n_count;
            r_pressed  <= n_pressed;
        end
    end

    assign o_res.event_key = event_key;
    assign o_res.held      = n_pressed;

endmodule

`default_nettype wire

// ----- src/adc_ladder_key_debouncer_core.sv -----
// An accepted sample passes from the input register through decode and tracking
// into the result register, which holds it until it is taken.
// Throughput: one sample per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (synchronous, active low) empties both registers, clears the debounce
// state and loads the default key windows and stable target.
// ----------------------------------------------------------------------------
// adc_ladder_key_debouncer_core
// Resistor-ladder five-way key decoder with press debouncing.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_ladder_key_debouncer_core
    import akd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration writes
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WIN_BITS-1:0]     i_cfg_wdata,
    // sample channel
    input  wire logic                    i_in_valid,
    output      logic                    o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]  i_adc_sample,
    // result channel
    output      logic                    o_out_valid,
    input  wire logic                    i_out_ready,
    output      logic [2:0]              o_key_event,
    output      logic [2:0]              o_raw_key,
    output      logic                    o_held
);

    t_win_set               r_wins;
    logic [TARGET_BITS-1:0] r_target;
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_out_valid;
    t_key                   r_event_key;
    t_key                   r_raw_key;
    logic                   r_held;
    logic                   advance;
    logic                   step;
    t_key                   raw_key;
    t_track_res             track_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wins.add_win    <= RST_ADD_WIN;
            r_wins.reduce_win <= RST_REDUCE_WIN;
            r_wins.enter_win  <= RST_ENTER_WIN;
            r_wins.back_win   <= RST_BACK_WIN;
            r_wins.down_win   <= RST_DOWN_WIN;
            r_target          <= RST_STABLE_TGT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADD_WIN:    r_wins.add_win    <= i_cfg_wdata;
                CFG_REDUCE_WIN: r_wins.reduce_win <= i_cfg_wdata;
                CFG_ENTER_WIN:  r_wins.enter_win  <= i_cfg_wdata;
                CFG_BACK_WIN:   r_wins.back_win   <= i_cfg_wdata;
                CFG_DOWN_WIN:   r_wins.down_win   <= i_cfg_wdata;
                CFG_STABLE_TGT: r_target          <= i_cfg_wdata[TARGET_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline moves when the result register is free or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign step       = r_in_valid && advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample <= i_adc_sample;
        end
    end

    akd_decode #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decode (
        .i_sample  (r_sample),
        .i_wins    (r_wins),
        .o_raw_key (raw_key)
    );

    akd_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_raw_key (raw_key),
        .i_target  (r_target),
        .o_res     (track_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event_key <= track_res.event_key;
            r_raw_key   <= raw_key;
            r_held      <= track_res.held;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_event = r_event_key;
    assign o_raw_key   = r_raw_key;
    assign o_held      = r_held;

endmodule

`default_nettype wire
